// ===== src/ors_pkg.sv =====
// Shared types and constants for the ordered record store.
package ors_pkg;

    localparam int MAX_RECORDS  = 16;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int POS_W  = 4;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TIME_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNTO_W = 5;
    localparam int PAY_W  = 64;

    localparam int IN_W  = 136;
    localparam int OUT_W = 112;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_GET    = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_SHIFT  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_MEM    = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [TIME_W-1:0]       stamp;
    } t_rec;

    typedef struct packed {
        logic              en;
        t_cmd              op;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
        t_rec              rec;
        logic [TIME_W-1:0] delta;
    } t_cell_ctl;

endpackage

// ===== src/ors_cell.sv =====
// One storage cell of the record chain: holds the record at one list position.
module ors_cell (
    input  logic                     i_clk,
    input  ors_pkg::t_cell_ctl       i_ctl,
    input  logic [ors_pkg::IDX_W-1:0] i_idx,
    input  ors_pkg::t_rec            i_next,
    output ors_pkg::t_rec            o_rec
);
    import ors_pkg::*;

    t_rec             r_rec;
    t_rec             n_rec;
    logic [CMP_W-1:0] w_idx;

    assign w_idx = CMP_W'(i_idx);

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                CMD_ADD: begin
                    if (w_idx == i_ctl.count) begin
                        n_rec = i_ctl.rec;
                    end
                end
                CMD_DELETE: begin
                    // close the gap: everything from the deleted position up moves down
                    if ((w_idx >= i_ctl.pos) && (i_ctl.pos < i_ctl.count)) begin
                        n_rec = i_next;
                    end
                end
                CMD_SHIFT: begin
                    if (w_idx < i_ctl.count) begin
                        n_rec.stamp = r_rec.stamp + i_ctl.delta;
                    end
                end
                default: begin
                    n_rec = r_rec;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ===== src/ordered_record_store.sv =====
// Ordered record store: top level with command decode, cell chain and result register.
//
// Holds up to MAX_RECORDS records (payload plus 32-bit timestamp) in a chain of cells
// ordered by insertion: cell i holds list position i. Add appends at the current count,
// get reads a list position, delete shifts every cell above the position down by one
// neighbor, shift adds a signed delta to every held timestamp (one adder per cell) and
// clear empties the store. Every command transaction yields exactly one result
// transaction. A command completes in the cycle it is accepted and its result is
// presented on the next cycle; the result register frees up in the cycle the result
// is taken, so one command per clock is sustained when the output side keeps up.
// Input is not taken during reset.
module ordered_record_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // cmd[2:0], rec_index[6:3], record_payload[70:7], record_time[102:71],
    // time_delta[134:103], zero pad[135]
    input  logic [ors_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // status[1:0], out_payload[65:2], out_time[97:66], record_count[102:98],
    // free_count[107:103], zero pad[111:108]
    output logic [ors_pkg::OUT_W-1:0] o_m_tdata
);
    import ors_pkg::*;

    logic              w_acc;
    t_cmd              w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_cnt_c;
    logic              w_pos_ok;
    logic              w_not_full;
    t_cell_ctl         w_ctl;
    t_rec              w_rec [MAX_RECORDS];
    t_rec              w_rd;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  w_free;

    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [PAY_W-1:0]  r_pay;
    logic [PAY_W-1:0]  n_pay;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;
    logic [CNTO_W-1:0] r_rcnt;
    logic [CNTO_W-1:0] r_fcnt;

    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign w_acc      = i_s_tvalid && o_s_tready;

    assign w_cmd      = t_cmd'(i_s_tdata[2:0]);
    assign w_pos      = i_s_tdata[6:3];
    assign w_pos_c    = CMP_W'(w_pos);
    assign w_cnt_c    = CMP_W'(r_count);
    assign w_pos_ok   = w_pos_c < w_cnt_c;
    assign w_not_full = w_cnt_c < CMP_W'(MAX_RECORDS);

    assign w_ctl.en            = w_acc;
    assign w_ctl.op            = w_cmd;
    assign w_ctl.pos           = w_pos_c;
    assign w_ctl.count         = w_cnt_c;
    assign w_ctl.rec.payload   = i_s_tdata[7 +: PAYLOAD_BITS];
    assign w_ctl.rec.stamp     = i_s_tdata[71 +: TIME_W];
    assign w_ctl.delta         = i_s_tdata[103 +: TIME_W];

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        t_rec w_next;
        if (g == MAX_RECORDS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_rec[g+1];
        end
        ors_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_idx  (IDX_W'(g)),
            .i_next (w_next),
            .o_rec  (w_rec[g])
        );
    end

    assign w_rd = w_rec[IDX_W'(w_pos)];

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pay    = '0;
        n_time   = '0;
        unique case (w_cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_ADD: begin
                if (w_not_full) begin
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_status = ST_NO_MEM;
                end
            end
            CMD_GET: begin
                if (w_pos_ok) begin
                    n_pay  = PAY_W'(w_rd.payload);
                    n_time = w_rd.stamp;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            CMD_DELETE: begin
                if (w_pos_ok) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_free = CNT_W'(MAX_RECORDS) - n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_pay    <= n_pay;
            r_time   <= n_time;
            r_rcnt   <= CNTO_W'(n_count);
            r_fcnt   <= CNTO_W'(w_free);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_fcnt, r_rcnt, r_time, r_pay, r_status};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_cmd == CMD_ADD) && w_not_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("add did not grow the count");

    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_cmd == CMD_DELETE) && w_pos_ok) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not shrink the count");

    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_rcnt + r_fcnt) == CNTO_W'(MAX_RECORDS)))
        else $error("record and free counts disagree");

    a_bad_get_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> ((r_pay == '0) && (r_time == '0)))
        else $error("failed command returned data");

endmodule
